// File: sv/tse_pkg.sv
package tse_pkg;

   localparam int unsigned PACKET_BYTES = 188;
   localparam int unsigned PES_SPAN     = 14;

   localparam logic [7:0] POS_LAST       = 8'(PACKET_BYTES - 1);
   localparam logic [7:0] PAYLOAD_MAX    = 8'(PACKET_BYTES - PES_SPAN);
   localparam logic [7:0] NO_PAYLOAD     = 8'hFF;
   localparam logic [7:0] POS_PID_HI     = 8'd1;
   localparam logic [7:0] POS_PID_LO     = 8'd2;
   localparam logic [7:0] POS_HDR_FLAGS  = 8'd3;
   localparam logic [7:0] POS_ADAPT_LEN  = 8'd4;
   localparam logic [7:0] POS_ADAPT_FLG  = 8'd5;
   localparam logic [7:0] POS_PCR_FIRST  = 8'd6;
   localparam logic [7:0] POS_PCR_LAST   = 8'd11;
   localparam logic [7:0] PAYLOAD_NOADPT = 8'd4;
   localparam logic [7:0] ADAPT_HDR_LEN  = 8'd5;
   localparam logic [7:0] PCR_MIN_LEN    = 8'd7;

   localparam logic [8:0] PCR_MULT = 9'd300;

   localparam logic [7:0] SID_PSM   = 8'hBC;
   localparam logic [7:0] SID_PAD   = 8'hBE;
   localparam logic [7:0] SID_PRIV2 = 8'hBF;
   localparam logic [7:0] SID_ECM   = 8'hF0;
   localparam logic [7:0] SID_EMM   = 8'hF1;
   localparam logic [7:0] SID_DSMCC = 8'hF2;
   localparam logic [7:0] SID_H222E = 8'hF8;
   localparam logic [7:0] SID_PSD   = 8'hFF;

   typedef struct packed {
      logic [12:0] pid;
      logic        pcr_ok;
      logic [32:0] pcr_base;
      logic [8:0]  pcr_ext;
      logic        pts_ok;
      logic [32:0] pts;
   } tse_entry_type;

endpackage

// File: sv/tse_front.sv
module tse_front import tse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tuser,
   input  logic          q_full,
   output logic          q_push,
   output tse_entry_type q_entry
);

   logic [7:0]  pos_ff, pos_in;
   logic        pend_ff, pend_in;
   logic        pusi_ff;
   logic [12:0] pid_ff;
   logic [7:0]  hflags_ff;
   logic [7:0]  alen_ff;
   logic [7:0]  aflags_ff;
   logic [47:0] pcr_bytes_ff;
   logic [7:0]  ps_ff;
   logic [7:0]  pes_ff [PES_SPAN];

   logic       acc;
   logic [7:0] pos;
   logic [7:0] idx;
   logic       cap;
   logic [8:0] off;

   function automatic logic lacks_opt_hdr(input logic [7:0] sid);
      logic r;
      case (sid) inside
         SID_PSM, SID_PAD, SID_PRIV2, SID_ECM, SID_EMM, SID_DSMCC, SID_H222E, SID_PSD: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   assign req_tready = !(pend_ff && q_full);
   assign acc        = req_tvalid && req_tready;
   assign pos        = req_tuser ? 8'd0 : pos_ff;
   assign idx        = pos - ps_ff;
   assign off        = 9'(ADAPT_HDR_LEN) + {1'b0, req_tdata};
   assign cap        = (pos >= POS_ADAPT_LEN) && (ps_ff <= PAYLOAD_MAX) && (pos >= ps_ff)
                       && (idx < 8'(PES_SPAN));
   assign q_push     = pend_ff && !q_full;

   always_comb begin
      pos_in  = pos_ff;
      pend_in = pend_ff;
      if (q_push) begin
         pend_in = 1'b0;
      end
      if (acc) begin
         if (pos == POS_LAST) begin
            pos_in  = 8'd0;
            pend_in = 1'b1;
         end else begin
            pos_in = pos + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 8'd0;
         pend_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         if (pos == POS_PID_HI) begin
            pusi_ff <= req_tdata[6];
            pid_ff  <= {req_tdata[4:0], 8'd0};
         end else if (pos == POS_PID_LO) begin
            pid_ff[7:0] <= req_tdata;
         end else if (pos == POS_HDR_FLAGS) begin
            hflags_ff <= req_tdata;
            ps_ff     <= req_tdata[5] ? NO_PAYLOAD : PAYLOAD_NOADPT;
         end else if (pos == POS_ADAPT_LEN) begin
            alen_ff <= req_tdata;
            if (hflags_ff[5]) begin
               ps_ff <= (off > 9'(PAYLOAD_MAX)) ? NO_PAYLOAD : off[7:0];
            end
         end else if (pos == POS_ADAPT_FLG) begin
            aflags_ff <= req_tdata;
         end
         if (pos >= POS_PCR_FIRST && pos <= POS_PCR_LAST) begin
            pcr_bytes_ff <= {pcr_bytes_ff[39:0], req_tdata};
         end
      end
   end

   for (genvar i = 0; i < PES_SPAN; i++) begin : g_pes
      always_ff @(posedge clock) begin
         if (acc && cap && idx[3:0] == 4'(i)) begin
            pes_ff[i] <= req_tdata;
         end
      end
   end

   always_comb begin
      q_entry.pid    = pid_ff;
      q_entry.pcr_ok = hflags_ff[5] && (alen_ff >= PCR_MIN_LEN) && aflags_ff[4];
      q_entry.pts_ok = pusi_ff && hflags_ff[4] && (ps_ff <= PAYLOAD_MAX)
                       && pes_ff[0] == 8'h00 && pes_ff[1] == 8'h00 && pes_ff[2] == 8'h01
                       && !lacks_opt_hdr(pes_ff[3])
                       && pes_ff[6][7:6] == 2'b10 && pes_ff[7][7];
      q_entry.pcr_base = q_entry.pcr_ok ? pcr_bytes_ff[47:15] : 33'd0;
      q_entry.pcr_ext  = q_entry.pcr_ok ? pcr_bytes_ff[8:0] : 9'd0;
      q_entry.pts      = q_entry.pts_ok ? {pes_ff[9][3:1], pes_ff[10], pes_ff[11][7:1],
                                           pes_ff[12], pes_ff[13][7:1]} : 33'd0;
   end

endmodule

// File: sv/tse_fifo.sv
module tse_fifo import tse_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tse_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output tse_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tse_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/tse_back.sv
module tse_back import tse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  tse_entry_type head_entry,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [95:0]   rsp_tdata
);

   logic        valid_ff, valid_in;
   logic [95:0] data_ff, data_in;
   logic [41:0] pcr;

   assign pop = head_valid && (!valid_ff || rsp_tready);
   assign pcr = 42'(head_entry.pcr_base) * 42'(PCR_MULT) + 42'(head_entry.pcr_ext);

   always_comb begin
      valid_in = valid_ff;
      data_in  = {6'd0, head_entry.pts, head_entry.pts_ok, pcr, head_entry.pcr_ok,
                  head_entry.pid};
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (pop) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// File: sv/ts_timestamp_extractor_core.sv
// Transport stream timestamp extractor: takes 188-byte packets one byte per transfer and, one
// transfer per packet, reports the PID, the 27 MHz PCR (base*300+extension) when the adaptation
// field carries one, and the 33-bit PTS of a PES header starting in the payload. req_tuser high
// marks byte 0 and restarts the count, dropping a partial packet; without it the count wraps after
// byte 187. The input takes one byte per clock while req_tready is high. A finished packet's
// fields go to the queue and are multiplied into the output register; up to QUEUE_DEPTH results
// wait in the queue while the output stalls, and only when it is full does req_tready drop.
module ts_timestamp_extractor_core import tse_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // first_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata    // packet_pid, pcr_found, pcr_value, pts_found, pts_value
);

   tse_entry_type push_entry;
   tse_entry_type head_entry;
   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          head_valid;

   tse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   tse_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: sv/tse_checker.sv
module tse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_pcr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[13] |-> rsp_tdata[55:14] == 42'd0)
      else $error("pcr value without pcr flag");

   a_pts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[56] |-> rsp_tdata[89:57] == 33'd0)
      else $error("pts value without pts flag");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[95:90] == 6'd0)
      else $error("nonzero padding");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

endmodule

bind ts_timestamp_extractor_core tse_checker u_tse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
